@@ rtl/core/wpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wpsp_pkg
// Shared types and constants of the WAV PCM stream parser: result record,
// result kinds, error codes and the default depth of the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsp_pkg;

    // Default number of entries in the result queue
    localparam int unsigned ResFifoDepth = 4;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_INFO   = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NOT_RIFF = 2'd0,
        ERR_NOT_WAVE = 2'd1,
        ERR_FORMAT   = 2'd2,
        ERR_DEPTH    = 2'd3
    } t_err;

    // One result record as it leaves the block
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] sample;
        logic [31:0]        rate;
        logic [15:0]        channels;
        logic [5:0]         bits;
        t_err               err;
        logic               last;
    } t_result;

    // Results caused by one accepted byte, in order (r0 first)
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_emit;

endpackage

`default_nettype wire

@@ rtl/core/wpsp_parse.sv @@
// ----------------------------------------------------------------------------
// wpsp_parse
// Byte-serial RIFF/WAVE parser core. Holds the parse state and, for each
// accepted byte, computes the next state and up to two result records.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsp_parse
    import wpsp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_final_byte,
    output t_emit           o_emit
);

    typedef enum logic [3:0] {
        PH_RIFF    = 4'd0,
        PH_RSIZE   = 4'd1,
        PH_WAVE    = 4'd2,
        PH_CID     = 4'd3,
        PH_SZFMT   = 4'd4,
        PH_SZDATA  = 4'd5,
        PH_SZOTHER = 4'd6,
        PH_FTAG    = 4'd7,
        PH_FCH     = 4'd8,
        PH_FRATE   = 4'd9,
        PH_FBRATE  = 4'd10,
        PH_FALIGN  = 4'd11,
        PH_FBITS   = 4'd12,
        PH_SKIP    = 4'd13,
        PH_DATA    = 4'd14,
        PH_DONE    = 4'd15
    } t_phase;

    // Four-character tags as they appear after little-endian collection
    localparam logic [31:0] TagRiff = 32'h4646_4952;
    localparam logic [31:0] TagWave = 32'h4556_4157;
    localparam logic [31:0] TagFmt  = 32'h2074_6D66;
    localparam logic [31:0] TagData = 32'h6174_6164;
    localparam logic [32:0] PosMax  = '1;

    function automatic t_result mk_result(t_kind k, logic [31:0] smp, logic [31:0] rate,
                                          logic [15:0] ch, logic [5:0] bits, t_err err);
        t_result r;
        r.kind     = k;
        r.sample   = $signed(smp);
        r.rate     = rate;
        r.channels = ch;
        r.bits     = bits;
        r.err      = err;
        r.last     = 1'b0;
        return r;
    endfunction

    // State registers
    t_phase      r_phase,  n_phase,  c_phase;
    logic [2:0]  r_idx,    n_idx,    c_idx;
    logic [31:0] r_field,  n_field,  c_field;
    logic [32:0] r_limit,  n_limit,  c_limit;
    logic [32:0] r_pos,    n_pos,    c_pos;
    logic [32:0] r_left,   n_left,   c_left;
    logic [15:0] r_ftag,   n_ftag,   c_ftag;
    logic [15:0] r_ch,     n_ch,     c_ch;
    logic [31:0] r_rate,   n_rate,   c_rate;
    logic [15:0] r_depth,  n_depth,  c_depth;
    logic [17:0] r_fsize,  n_fsize,  c_fsize;
    logic [17:0] r_fidx,   n_fidx,   c_fidx;
    logic        r_fits,   n_fits,   c_fits;
    logic [31:0] r_sshift, n_sshift, c_sshift;

    // Step intermediates
    logic [31:0] sh;
    logic        col_w2, col_w4, collecting, done, cid_fail;
    logic [32:0] left_dec, left_fmt;
    logic [17:0] fsize_new, fidx_inc;
    logic [31:0] sshift_new;
    logic        a_vld, b_vld, l_vld;
    t_result     a_res, b_res, l_res;
    logic [1:0]  cnt;

    // Next-state and result logic for one byte
    always_comb begin
        // first_byte restarts from the reset state
        c_phase  = i_first_byte ? PH_RIFF : r_phase;
        c_idx    = i_first_byte ? '0 : r_idx;
        c_field  = i_first_byte ? '0 : r_field;
        c_limit  = i_first_byte ? '0 : r_limit;
        c_pos    = i_first_byte ? '0 : r_pos;
        c_left   = i_first_byte ? '0 : r_left;
        c_ftag   = i_first_byte ? '0 : r_ftag;
        c_ch     = i_first_byte ? '0 : r_ch;
        c_rate   = i_first_byte ? '0 : r_rate;
        c_depth  = i_first_byte ? '0 : r_depth;
        c_fsize  = i_first_byte ? '0 : r_fsize;
        c_fidx   = i_first_byte ? '0 : r_fidx;
        c_fits   = i_first_byte ? 1'b0 : r_fits;
        c_sshift = i_first_byte ? '0 : r_sshift;

        n_phase  = c_phase;
        n_idx    = c_idx;
        n_field  = c_field;
        n_limit  = c_limit;
        n_pos    = c_pos;
        n_left   = c_left;
        n_ftag   = c_ftag;
        n_ch     = c_ch;
        n_rate   = c_rate;
        n_depth  = c_depth;
        n_fsize  = c_fsize;
        n_fidx   = c_fidx;
        n_fits   = c_fits;
        n_sshift = c_sshift;

        a_vld = 1'b0;
        b_vld = 1'b0;
        l_vld = 1'b0;
        a_res = '0;
        b_res = mk_result(KIND_END, '0, '0, '0, '0, ERR_NOT_RIFF);
        l_res = '0;

        sh         = {i_data_byte, c_field[31:8]};
        left_dec   = (c_left != '0) ? c_left - 33'd1 : c_left;
        left_fmt   = (c_left > 33'd16) ? c_left - 33'd16 : '0;
        fsize_new  = {2'b00, c_ch} * {15'd0, c_depth[5:3]};
        fidx_inc   = c_fidx + 18'd1;
        sshift_new = (c_fidx < {15'd0, c_depth[5:3]}) ? {i_data_byte, c_sshift[31:8]}
                                                      : c_sshift;
        cid_fail   = (c_phase == PH_CID) && (c_idx == '0) && (c_pos >= c_limit);

        // Field width of the collecting phases
        col_w2 = 1'b0;
        col_w4 = 1'b0;
        case (c_phase)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_SZFMT, PH_SZDATA,
            PH_SZOTHER, PH_FRATE, PH_FBRATE: begin
                col_w4 = 1'b1;
            end
            PH_FTAG, PH_FCH, PH_FALIGN, PH_FBITS: begin
                col_w2 = 1'b1;
            end
            default: begin
            end
        endcase
        collecting = (col_w2 || col_w4) && !cid_fail;
        done       = col_w2 ? (c_idx >= 3'd1) : (c_idx >= 3'd3);

        if (i_accept && (c_phase != PH_DONE)) begin
            n_pos = (c_pos != PosMax) ? c_pos + 33'd1 : c_pos;

            // Little-endian field collection
            if (collecting) begin
                n_field = sh;
                n_idx   = done ? '0 : c_idx + 3'd1;
            end

            case (c_phase)
                PH_RIFF: begin
                    if (done) begin
                        if (sh != TagRiff) begin
                            a_vld   = 1'b1;
                            a_res   = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_NOT_RIFF);
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_RSIZE;
                        end
                    end
                end
                PH_RSIZE: begin
                    if (done) begin
                        n_limit = 33'd8 + {1'b0, sh};
                        n_phase = PH_WAVE;
                    end
                end
                PH_WAVE: begin
                    if (done) begin
                        if (sh != TagWave) begin
                            a_vld   = 1'b1;
                            a_res   = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_NOT_WAVE);
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_CID;
                        end
                    end
                end
                PH_CID: begin
                    if (cid_fail) begin
                        a_vld   = 1'b1;
                        a_res   = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_FORMAT);
                        n_phase = PH_DONE;
                    end else if (done) begin
                        if (sh == TagFmt) begin
                            n_phase = PH_SZFMT;
                        end else if (sh == TagData) begin
                            n_phase = PH_SZDATA;
                        end else begin
                            n_phase = PH_SZOTHER;
                        end
                    end
                end
                PH_SZFMT: begin
                    if (done) begin
                        n_left  = {1'b0, sh};
                        n_phase = PH_FTAG;
                    end
                end
                PH_SZDATA: begin
                    if (done) begin
                        if ((c_ftag != 16'd1) || (sh == '0) || (c_depth == '0)
                            || (c_ch == '0)) begin
                            a_vld   = 1'b1;
                            a_res   = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_FORMAT);
                            n_phase = PH_DONE;
                        end else if ((c_depth != 16'd16) && (c_depth != 16'd24)
                                     && (c_depth != 16'd32)) begin
                            a_vld   = 1'b1;
                            a_res   = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_DEPTH);
                            n_phase = PH_DONE;
                        end else begin
                            a_vld    = 1'b1;
                            a_res    = mk_result(KIND_INFO, '0, c_rate, c_ch, c_depth[5:0],
                                                 ERR_NOT_RIFF);
                            n_left   = {1'b0, sh};
                            n_fsize  = fsize_new;
                            n_fidx   = '0;
                            n_sshift = '0;
                            n_fits   = ({1'b0, sh} >= {15'd0, fsize_new});
                            n_phase  = PH_DATA;
                        end
                    end
                end
                PH_SZOTHER: begin
                    if (done) begin
                        // unknown chunks are padded to even length
                        n_left  = {1'b0, sh} + {32'd0, sh[0]};
                        n_phase = (sh != '0) ? PH_SKIP : PH_CID;
                    end
                end
                PH_FTAG: begin
                    if (done) begin
                        n_ftag  = sh[31:16];
                        n_phase = PH_FCH;
                    end
                end
                PH_FCH: begin
                    if (done) begin
                        n_ch    = sh[31:16];
                        n_phase = PH_FRATE;
                    end
                end
                PH_FRATE: begin
                    if (done) begin
                        n_rate  = sh;
                        n_phase = PH_FBRATE;
                    end
                end
                PH_FBRATE: begin
                    if (done) begin
                        n_phase = PH_FALIGN;
                    end
                end
                PH_FALIGN: begin
                    if (done) begin
                        n_phase = PH_FBITS;
                    end
                end
                PH_FBITS: begin
                    if (done) begin
                        n_depth = sh[31:16];
                        n_left  = left_fmt;
                        n_phase = (left_fmt != '0) ? PH_SKIP : PH_CID;
                    end
                end
                PH_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_CID;
                    end
                end
                PH_DATA: begin
                    n_sshift = sshift_new;
                    n_left   = left_dec;
                    // frame complete: emit channel 0 if the frame fit the chunk
                    if (fidx_inc >= c_fsize) begin
                        if (c_fits) begin
                            a_vld = 1'b1;
                            a_res = mk_result(KIND_SAMPLE, sshift_new, '0, '0, '0,
                                              ERR_NOT_RIFF);
                        end
                        n_fidx   = '0;
                        n_sshift = '0;
                        n_fits   = (left_dec >= {15'd0, c_fsize});
                    end else begin
                        n_fidx = fidx_inc;
                    end
                    if (left_dec == '0) begin
                        b_vld   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            // Truncated stream
            if (i_final_byte && (n_phase != PH_DONE)) begin
                l_vld = 1'b1;
                case (n_phase)
                    PH_DATA: begin
                        l_res = mk_result(KIND_END, '0, '0, '0, '0, ERR_NOT_RIFF);
                    end
                    PH_RIFF: begin
                        l_res = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_NOT_RIFF);
                    end
                    PH_RSIZE, PH_WAVE: begin
                        l_res = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_NOT_WAVE);
                    end
                    default: begin
                        l_res = mk_result(KIND_ERROR, '0, '0, '0, '0, ERR_FORMAT);
                    end
                endcase
                n_phase = PH_DONE;
            end
        end

        // Pack results in order; at most two per byte
        cnt         = {1'b0, a_vld} + {1'b0, b_vld} + {1'b0, l_vld};
        o_emit.count = cnt;
        o_emit.r0    = a_vld ? a_res : (b_vld ? b_res : l_res);
        o_emit.r1    = a_vld ? (b_vld ? b_res : l_res) : l_res;
        o_emit.r0.last = (cnt == 2'd1);
        o_emit.r1.last = 1'b1;
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_RIFF;
            r_idx    <= '0;
            r_field  <= '0;
            r_limit  <= '0;
            r_pos    <= '0;
            r_left   <= '0;
            r_ftag   <= '0;
            r_ch     <= '0;
            r_rate   <= '0;
            r_depth  <= '0;
            r_fsize  <= '0;
            r_fidx   <= '0;
            r_fits   <= 1'b0;
            r_sshift <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_field  <= n_field;
            r_limit  <= n_limit;
            r_pos    <= n_pos;
            r_left   <= n_left;
            r_ftag   <= n_ftag;
            r_ch     <= n_ch;
            r_rate   <= n_rate;
            r_depth  <= n_depth;
            r_fsize  <= n_fsize;
            r_fidx   <= n_fidx;
            r_fits   <= n_fits;
            r_sshift <= n_sshift;
        end
    end

    // A final byte always closes the stream
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_final_byte |=> r_phase == PH_DONE)
        else $error("parser not done after final byte");

    // A second result of one byte can only be end of samples
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.count == 2'd2 |-> o_emit.r1.kind == KIND_END)
        else $error("unexpected second result");

    // Frame byte index stays inside the frame while streaming
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_fidx < r_fsize)
        else $error("frame index out of range");

endmodule

`default_nettype wire

@@ rtl/core/wpsp_res_fifo.sv @@
// ----------------------------------------------------------------------------
// wpsp_res_fifo
// Result queue. Takes up to two records per cycle from the parser and hands
// them out one per output transaction. Signals room while two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsp_res_fifo
    import wpsp_pkg::*;
#(
    parameter int unsigned DEPTH = ResFifoDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_emit i_emit,
    input  wire logic  i_pop,
    output t_result    o_head,
    output logic       o_valid,
    output logic       o_room
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr, r_rd, n_rd, wr1;
    logic [CW-1:0]  r_count, n_count;
    logic           pop;

    // Pointer and occupancy update
    always_comb begin
        pop     = i_pop && o_valid;
        wr1     = ptr_inc(r_wr);
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        case (i_emit.count)
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = ptr_inc(wr1);
            default: n_wr = r_wr;
        endcase
        n_count = r_count + CW'(i_emit.count) - CW'(pop);
    end

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr] <= i_emit.r0;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[wr1] <= i_emit.r1;
        end
    end

    // Occupancy never exceeds the queue depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= int'(DEPTH))
        else $error("result queue occupancy out of range");

    // Parser never pushes more than the free space
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) + int'(i_emit.count) - int'(pop) <= int'(DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire

@@ rtl/core/wav_pcm_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_unit
// Byte-serial WAV (RIFF/WAVE PCM) parser with a valid/ready byte input and a
// valid/ready result output.
//
// Input channel: one file byte per transaction, with first_byte to restart
// parsing and final_byte to mark the end of the stream.
// Output channel: one result per transaction: a Q1.31 channel 0 sample, the
// stream info, an error code, or end of samples. run_last flags the last
// result caused by a byte (a byte causes zero, one or two results).
// Results of a byte are held in the result queue from the cycle after it is accepted.
// Throughput: one byte per cycle; a byte is taken while at least two queue
// entries are free, so with the receiver taking results the input never waits.
// Stall: when the receiver holds ready low, results wait in the queue
// (RES_DEPTH entries) and the input stops once fewer than two are free,
// until the receiver drains the queue again.
// Reset: synchronous; the parser waits for a RIFF tag and the queue empties.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm_stream_parser_unit
    import wpsp_pkg::*;
#(
    parameter int unsigned RES_DEPTH = ResFifoDepth
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // byte input
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_first_byte,
    input  wire logic         i_final_byte,
    // result output
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [1:0]        o_result_kind,
    output logic signed [31:0] o_sample_value,
    output logic [31:0]       o_rate_hz,
    output logic [15:0]       o_channel_count,
    output logic [5:0]        o_sample_bits,
    output logic [1:0]        o_error_code,
    output logic              o_run_last
);

    logic    room;
    logic    accept;
    t_emit   emit;
    t_result head;

    assign o_ready = room;
    assign accept  = i_valid && room;

    wpsp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_final_byte (i_final_byte),
        .o_emit       (emit)
    );

    wpsp_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_pop   (i_ready),
        .o_head  (head),
        .o_valid (o_valid),
        .o_room  (room)
    );

    // Result fields
    assign o_result_kind   = head.kind;
    assign o_sample_value  = head.sample;
    assign o_rate_hz       = head.rate;
    assign o_channel_count = head.channels;
    assign o_sample_bits   = head.bits;
    assign o_error_code    = head.err;
    assign o_run_last      = head.last;

endmodule

`default_nettype wire
